// ===== rtl/srcb_pkg.sv =====
// Shared types and constants for the SATA read command builder.
package srcb_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
    localparam logic [1:0] STATUS_ZERO     = 2'd2;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd3;

    // Bytes per sector and buffer advance per descriptor entry.
    localparam int unsigned SECTOR_BYTES = 512;
    localparam logic [31:0] ADDR_STRIDE  = 32'h0001_0000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COUNT,
        ST_EMIT,
        ST_ERROR
    } state_t;

    // Operations of the shared adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Per-cycle control produced by the sequencer.
    typedef struct packed {
        logic    load_req;
        logic    scan_step;
        logic    scan_found;
        logic    scan_fail;
        logic    count_step;
        logic    count_over;
        logic    emit_fire;
        logic    error_fire;
        alu_op_t alu_op;
    } ctrl_t;

endpackage

// ===== rtl/srcb_in_if.sv =====
// Request channel interface carrying one read request per item.
interface srcb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] slot_busy_mask;
    logic [31:0] buffer_address;
    logic [47:0] start_sector;
    logic [15:0] sector_count;

    modport source (
        output valid, slot_busy_mask, buffer_address, start_sector, sector_count,
        input  ready
    );
    modport sink (
        input  valid, slot_busy_mask, buffer_address, start_sector, sector_count,
        output ready
    );
endinterface

// ===== rtl/srcb_out_if.sv =====
// Result channel interface carrying one descriptor entry per item.
interface srcb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [6:0]  entry_count;
    logic [5:0]  entry_index;
    logic [31:0] entry_address;
    logic [15:0] entry_bytes_minus_one;
    logic [47:0] frame_sector;
    logic [15:0] frame_count;
    logic        last;

    modport source (
        output valid, status, slot, entry_count, entry_index, entry_address,
               entry_bytes_minus_one, frame_sector, frame_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot, entry_count, entry_index, entry_address,
               entry_bytes_minus_one, frame_sector, frame_count, last,
        output ready
    );
endinterface

// ===== rtl/srcb_alu.sv =====
// Shared 32-bit adder/subtractor with borrow, used by the count and emit phases.
module srcb_alu
    import srcb_pkg::*;
(
    input  alu_op_t     op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [32:0] res
);

    // Bit 32 of a subtraction is the borrow, set when a is below b.
    always_comb
    begin
        case (op)
            ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ALU_SUB: res = {1'b0, a} - {1'b0, b};
            default: res = {1'b0, a};
        endcase
    end

endmodule

// ===== rtl/sata_read_command_builder_unit.sv =====
// Top level of the SATA read command builder: slot pick, entry count and descriptor emit.
//
//  channel | modport | direction | moves
//  req     | sink    | in        | one read request item
//  rsp     | source  | out       | one descriptor entry item, or one error item
//
// A request is taken only in idle. The slot scan tests one busy bit a cycle,
// the count phase subtracts SECTORS_PER_ENTRY once a cycle through the shared
// adder, and the emit phase sends one entry a cycle while the output is free,
// stepping the address through the same adder.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// A stalled output holds the sequencer in emit or error until the item is taken.
module sata_read_command_builder_unit
    import srcb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES       = 64,
    parameter int unsigned SLOT_COUNT        = 32,
    parameter int unsigned SECTORS_PER_ENTRY = 128
)
(
    input  logic           clk,
    input  logic           rst_n,
    srcb_in_if.sink        req,
    srcb_out_if.source     rsp
);

    localparam logic [15:0] FULL_BYTES = 16'(SECTORS_PER_ENTRY * SECTOR_BYTES - 1);
    localparam logic [31:0] SPE        = 32'(SECTORS_PER_ENTRY);
    localparam logic [4:0]  LAST_SLOT  = 5'(SLOT_COUNT - 1);
    localparam logic [6:0]  MAX_CNT    = 7'(MAX_ENTRIES);

    state_t      state_reg, state_next;
    ctrl_t       ctrl;

    logic [31:0] busy_reg;
    logic [4:0]  scan_idx_reg;
    logic [4:0]  slot_reg;
    logic [31:0] addr_reg;
    logic [47:0] sector_reg;
    logic [15:0] remain_reg;
    logic [6:0]  entries_reg;
    logic [5:0]  idx_reg;
    logic [1:0]  err_status_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [4:0]  out_slot_reg;
    logic [6:0]  out_count_reg;
    logic [5:0]  out_index_reg;
    logic [31:0] out_addr_reg;
    logic [15:0] out_bytes_reg;
    logic [47:0] out_sector_reg;
    logic [15:0] out_fcount_reg;
    logic        out_last_reg;

    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [32:0] alu_res;
    logic        scan_free;
    logic        scan_end;
    logic        cnt_more;
    logic        cnt_full;
    logic        out_free;
    logic        emit_last;
    logic [16:0] last_bytes;

    // Shared adder: remaining count minus entry size, or address plus stride.
    assign alu_a = (ctrl.alu_op == ALU_SUB) ? {16'd0, remain_reg} : addr_reg;
    assign alu_b = (ctrl.alu_op == ALU_SUB) ? SPE : ADDR_STRIDE;

    srcb_alu u_alu (
        .op  (ctrl.alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Status conditions seen by the sequencer.
    assign scan_free  = !busy_reg[0];
    assign scan_end   = (scan_idx_reg == LAST_SLOT);
    assign cnt_more   = !alu_res[32] && (alu_res[31:0] != 32'd0);
    assign cnt_full   = (entries_reg == MAX_CNT);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign emit_last  = ({1'b0, idx_reg} + 7'd1 == entries_reg);
    assign last_bytes = {remain_reg[7:0], 9'd0} - 17'd1;

    assign req.ready  = (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_free)
                    state_next = (remain_reg == 16'd0) ? ST_ERROR : ST_COUNT;
                else if (scan_end)
                    state_next = ST_ERROR;
            end
            ST_COUNT:
            begin
                if (!cnt_more)
                    state_next = ST_EMIT;
                else if (cnt_full)
                    state_next = ST_ERROR;
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                    state_next = ST_IDLE;
            end
            ST_ERROR:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl = '0;
        ctrl.alu_op = ALU_ADD;
        case (state_reg)
            ST_IDLE:  ctrl.load_req = req.valid;
            ST_SCAN:
            begin
                ctrl.scan_found = scan_free;
                ctrl.scan_fail  = !scan_free && scan_end;
                ctrl.scan_step  = !scan_free && !scan_end;
            end
            ST_COUNT:
            begin
                ctrl.alu_op     = ALU_SUB;
                ctrl.count_step = cnt_more && !cnt_full;
                ctrl.count_over = cnt_more && cnt_full;
            end
            ST_EMIT:  ctrl.emit_fire  = out_free;
            ST_ERROR: ctrl.error_fire = out_free;
            default:  ctrl.alu_op = ALU_ADD;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers of the request.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_req)
        begin
            busy_reg     <= req.slot_busy_mask;
            scan_idx_reg <= 5'd0;
            addr_reg     <= req.buffer_address;
            sector_reg   <= req.start_sector;
            remain_reg   <= req.sector_count;
            entries_reg  <= 7'd1;
            idx_reg      <= 6'd0;
        end
        if (ctrl.scan_step)
        begin
            busy_reg     <= {1'b0, busy_reg[31:1]};
            scan_idx_reg <= scan_idx_reg + 5'd1;
        end
        if (ctrl.scan_found)
        begin
            slot_reg       <= scan_idx_reg;
            err_status_reg <= STATUS_ZERO;
        end
        if (ctrl.scan_fail)
        begin
            slot_reg       <= 5'd0;
            err_status_reg <= STATUS_NO_SLOT;
        end
        if (ctrl.count_step)
        begin
            remain_reg  <= alu_res[15:0];
            entries_reg <= entries_reg + 7'd1;
        end
        if (ctrl.count_over)
            err_status_reg <= STATUS_TOO_MANY;
        if (ctrl.emit_fire)
        begin
            addr_reg <= alu_res[31:0];
            idx_reg  <= idx_reg + 6'd1;
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit_fire || ctrl.error_fire)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.emit_fire)
        begin
            out_status_reg <= STATUS_OK;
            out_slot_reg   <= slot_reg;
            out_count_reg  <= entries_reg;
            out_index_reg  <= idx_reg;
            out_addr_reg   <= addr_reg;
            out_bytes_reg  <= emit_last ? last_bytes[15:0] : FULL_BYTES;
            out_sector_reg <= sector_reg;
            out_fcount_reg <= remain_reg;
            out_last_reg   <= emit_last;
        end
        else if (ctrl.error_fire)
        begin
            out_status_reg <= err_status_reg;
            out_slot_reg   <= slot_reg;
            out_count_reg  <= 7'd0;
            out_index_reg  <= 6'd0;
            out_addr_reg   <= 32'd0;
            out_bytes_reg  <= 16'd0;
            out_sector_reg <= 48'd0;
            out_fcount_reg <= 16'd0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid                 = out_valid_reg;
    assign rsp.status                = out_status_reg;
    assign rsp.slot                  = out_slot_reg;
    assign rsp.entry_count           = out_count_reg;
    assign rsp.entry_index           = out_index_reg;
    assign rsp.entry_address         = out_addr_reg;
    assign rsp.entry_bytes_minus_one = out_bytes_reg;
    assign rsp.frame_sector          = out_sector_reg;
    assign rsp.frame_count           = out_fcount_reg;
    assign rsp.last                  = out_last_reg;

    // An error item is always the only one of its request.
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.last && rsp.entry_count == 7'd0))
        else $error("error item is not a lone final item");

    // A good item is last exactly when it is the final entry of the table.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_OK) |->
        (rsp.last == ({1'b0, rsp.entry_index} + 7'd1 == rsp.entry_count)))
        else $error("last flag does not match entry index");

    // The entry count never runs past the table limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT || state_reg == ST_EMIT) |-> (entries_reg <= MAX_CNT))
        else $error("entry count exceeds table limit");

    // No new item is loaded while a result still waits.
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(out_addr_reg) && $stable(out_index_reg)))
        else $error("waiting result was overwritten");

endmodule

// ===== tb/tb_sata_read_command_builder_unit.sv =====
// Self-checking testbench for the SATA read command builder top level.
`timescale 1ns / 100ps

module tb_sata_read_command_builder_unit;
    import srcb_pkg::*;

    localparam int unsigned MAX_ENTRIES       = 64;
    localparam int unsigned SLOT_COUNT        = 32;
    localparam int unsigned SECTORS_PER_ENTRY = 128;
    localparam int unsigned RANDOM_REQUESTS   = 93;
    localparam int unsigned STALL_LIMIT       = 2000;
    localparam int unsigned DRAIN_CYCLES      = 200;

    // One read request as it appears on the request channel.
    typedef struct packed {
        logic [31:0] busy_mask;
        logic [31:0] buffer_address;
        logic [47:0] start_sector;
        logic [15:0] sector_count;
    } read_req_t;

    // One descriptor entry as it appears on the result channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [6:0]  entry_count;
        logic [5:0]  entry_index;
        logic [31:0] entry_address;
        logic [15:0] entry_bytes_minus_one;
        logic [47:0] frame_sector;
        logic [15:0] frame_count;
        logic        last;
    } prd_entry_t;

    // A directed request, with its single result written out where it is obvious.
    typedef struct {
        read_req_t  req;
        bit         typed;
        prd_entry_t want;
    } directed_row_t;

    bit clk;
    logic rst_n;
    int unsigned fails;
    int unsigned quiet_cycles;
    bit steady;
    prd_entry_t pending_entries[$];
    directed_row_t directed_rows[$];

    srcb_in_if  req_ch ();
    srcb_out_if rsp_ch ();

    sata_read_command_builder_unit #(
        .MAX_ENTRIES       (MAX_ENTRIES),
        .SLOT_COUNT        (SLOT_COUNT),
        .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Works out the descriptor entries of one request and queues them in order.
    function automatic void build_descriptors(read_req_t r);
        prd_entry_t  e;
        int unsigned free_slot;
        int unsigned n_entries;
        int unsigned tail_sectors;
        logic [31:0] addr;
        bit          found;
        e         = '0;
        e.last    = 1'b1;
        found     = 1'b0;
        free_slot = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!found && !r.busy_mask[i])
            begin
                free_slot = i;
                found     = 1'b1;
            end
        end
        if (!found)
        begin
            e.status = STATUS_NO_SLOT;
            pending_entries.push_back(e);
            return;
        end
        e.slot = free_slot[4:0];
        if (r.sector_count == 16'd0)
        begin
            e.status = STATUS_ZERO;
            pending_entries.push_back(e);
            return;
        end
        n_entries = (int'(r.sector_count) - 1) / SECTORS_PER_ENTRY + 1;
        if (n_entries > MAX_ENTRIES)
        begin
            e.status = STATUS_TOO_MANY;
            pending_entries.push_back(e);
            return;
        end
        tail_sectors = int'(r.sector_count) - (n_entries - 1) * SECTORS_PER_ENTRY;
        addr = r.buffer_address;
        for (int i = 0; i < n_entries; i++)
        begin
            e.status        = STATUS_OK;
            e.entry_count   = n_entries[6:0];
            e.entry_index   = i[5:0];
            e.entry_address = addr;
            e.frame_sector  = r.start_sector;
            e.frame_count   = tail_sectors[15:0];
            e.last          = (i == n_entries - 1);
            if (e.last)
                e.entry_bytes_minus_one = 16'(tail_sectors * SECTOR_BYTES - 1);
            else
                e.entry_bytes_minus_one = 16'(SECTORS_PER_ENTRY * SECTOR_BYTES - 1);
            pending_entries.push_back(e);
            addr = addr + ADDR_STRIDE;
        end
    endfunction

    // Builds a directed row; a typed one expects a single, easily read result.
    function automatic directed_row_t make_row(logic [31:0] mask, logic [31:0] addr,
                                               logic [47:0] lba, logic [15:0] cnt,
                                               bit typed, logic [1:0] st, logic [4:0] sl);
        directed_row_t row;
        row.req   = '{busy_mask: mask, buffer_address: addr, start_sector: lba,
                      sector_count: cnt};
        row.typed = typed;
        row.want  = '0;
        row.want.status = st;
        row.want.slot   = sl;
        row.want.last   = 1'b1;
        if (st == STATUS_OK)
        begin
            row.want.entry_count           = 7'd1;
            row.want.entry_address         = addr;
            row.want.entry_bytes_minus_one = 16'(int'(cnt) * SECTOR_BYTES - 1);
            row.want.frame_sector          = lba;
            row.want.frame_count           = cnt;
        end
        return row;
    endfunction

    // Presents one request after a random gap (none in steady stretches) and queues its results once taken.
    task automatic send_request(read_req_t r, bit typed, prd_entry_t want);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.slot_busy_mask <= r.busy_mask;
        req_ch.buffer_address <= r.buffer_address;
        req_ch.start_sector   <= r.start_sector;
        req_ch.sector_count   <= r.sector_count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (typed)
            pending_entries.push_back(want);
        else
            build_descriptors(r);
    endtask

    // Draws a random request: mostly well-formed ones, the rest error cases.
    function automatic read_req_t random_request();
        read_req_t   r;
        int unsigned kind;
        int unsigned free_slot;
        r.buffer_address = $urandom;
        r.start_sector   = {16'($urandom), 32'($urandom)};
        r.busy_mask      = $urandom;
        kind             = $urandom_range(0, 99);
        free_slot        = $urandom_range(0, SLOT_COUNT - 1);
        if ($urandom_range(0, 1) == 0)
            free_slot = $urandom_range(0, 4);
        r.busy_mask = r.busy_mask | ((32'd1 << free_slot) - 32'd1);
        r.busy_mask[free_slot] = 1'b0;
        if (kind < 8)
        begin
            r.busy_mask    = '1;
            r.sector_count = 16'($urandom);
        end
        else if (kind < 14)
            r.sector_count = 16'd0;
        else if (kind < 22)
            r.sector_count = 16'($urandom_range(MAX_ENTRIES * SECTORS_PER_ENTRY + 1, 65535));
        else if (kind < 32)
            r.sector_count = 16'($urandom_range(1, MAX_ENTRIES * SECTORS_PER_ENTRY));
        else
            r.sector_count = 16'($urandom_range(1, 600));
        return r;
    endfunction

    // Reports one field that differs from its expectation.
    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    // Result side: random stall before each item (none in steady stretches), then ready until it is taken.
    initial
    begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // Compares every accepted result with the oldest pending entry.
    always @(posedge clk)
    begin
        prd_entry_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_entries.size() == 0)
            begin
                $display("%0t ns: result expected none, got status 0x%0h slot 0x%0h",
                         $time, rsp_ch.status, rsp_ch.slot);
                fails++;
            end
            else
            begin
                want = pending_entries.pop_front();
                compare_field("status", 64'(want.status), 64'(rsp_ch.status));
                compare_field("slot", 64'(want.slot), 64'(rsp_ch.slot));
                compare_field("entry_count", 64'(want.entry_count),
                              64'(rsp_ch.entry_count));
                compare_field("entry_index", 64'(want.entry_index),
                              64'(rsp_ch.entry_index));
                compare_field("entry_address", 64'(want.entry_address),
                              64'(rsp_ch.entry_address));
                compare_field("entry_bytes_minus_one", 64'(want.entry_bytes_minus_one),
                              64'(rsp_ch.entry_bytes_minus_one));
                compare_field("frame_sector", 64'(want.frame_sector),
                              64'(rsp_ch.frame_sector));
                compare_field("frame_count", 64'(want.frame_count),
                              64'(rsp_ch.frame_count));
                compare_field("last", 64'(want.last), 64'(rsp_ch.last));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Reset, directed requests, random requests, then drain and verdict.
    initial
    begin
        read_req_t r;
        fails        = 0;
        quiet_cycles = 0;
        steady       = 1'b0;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.slot_busy_mask <= '0;
        req_ch.buffer_address <= '0;
        req_ch.start_sector   <= '0;
        req_ch.sector_count   <= '0;

        // Single sector just after reset, then the error codes and the extremes.
        directed_rows.push_back(make_row(32'h0, 32'h0, 48'h0, 16'd1, 1'b1, STATUS_OK, 5'd0));
        directed_rows.push_back(make_row('1, 32'h1234_5678, 48'h1, 16'd1, 1'b1,
                                         STATUS_NO_SLOT, 5'd0));
        directed_rows.push_back(make_row('1, 32'h0, 48'h0, 16'd0, 1'b1,
                                         STATUS_NO_SLOT, 5'd0));
        directed_rows.push_back(make_row(32'h0, 32'h0, 48'h0, 16'd0, 1'b1,
                                         STATUS_ZERO, 5'd0));
        directed_rows.push_back(make_row(32'h7FFF_FFFF, '1, '1, 16'd0, 1'b1,
                                         STATUS_ZERO, 5'd31));
        directed_rows.push_back(make_row(32'h0000_FFFF, 32'h0, 48'h0, 16'd8193, 1'b1,
                                         STATUS_TOO_MANY, 5'd16));
        directed_rows.push_back(make_row(32'h0, '1, '1, 16'hFFFF, 1'b1,
                                         STATUS_TOO_MANY, 5'd0));
        directed_rows.push_back(make_row(32'h0, 32'h0, 48'h0, 16'h8000, 1'b1,
                                         STATUS_TOO_MANY, 5'd0));
        directed_rows.push_back(make_row(32'hFFFF_FFFE, 32'h0, 48'h0, 16'h4000, 1'b1,
                                         STATUS_TOO_MANY, 5'd0));
        directed_rows.push_back(make_row(32'h7FFF_FFFF, '1, '1, 16'd128, 1'b1,
                                         STATUS_OK, 5'd31));
        directed_rows.push_back(make_row(32'h0000_0003, 32'hABCD_0000, 48'h5, 16'd127, 1'b1,
                                         STATUS_OK, 5'd2));
        // Multi-entry requests: full entries plus a short tail, address wrap, the limit.
        directed_rows.push_back(make_row(32'h0, 32'h1000_0000, 48'h10, 16'd129, 1'b0,
                                         STATUS_OK, 5'd0));
        directed_rows.push_back(make_row(32'h0, 32'hFFFF_0000, '1, 16'd8192, 1'b0,
                                         STATUS_OK, 5'd0));
        directed_rows.push_back(make_row(32'h5555_5555, 32'hFFFF_FFFF, 48'h0, 16'd8191, 1'b0,
                                         STATUS_OK, 5'd1));
        directed_rows.push_back(make_row(32'hAAAA_AAAA, 32'h0000_8000, 48'h1234_5678_9ABC,
                                         16'd256, 1'b0, STATUS_OK, 5'd0));
        directed_rows.push_back(make_row(32'hFFFF_FEFF, 32'h8000_0000, 48'h8000_0000_0000,
                                         16'd1000, 1'b0, STATUS_OK, 5'd8));
        directed_rows.push_back(make_row(32'hFFFF_7FFF, 32'hDEAD_BEEF, 48'h0FFF_FFFF_FFFF,
                                         16'd385, 1'b0, STATUS_OK, 5'd15));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);

        // Random part; every third stretch of sixteen runs with no idling.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady = ((n / 16) % 3 == 2);
            r = random_request();
            send_request(r, 1'b0, '0);
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0 && pending_entries.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
